[design/ptr_pkg.sv]
// Shared types, widths and codes for the perspective triangle rasteriser.
package ptr_pkg;

  localparam int SCREEN_WIDTH  = 512;
  localparam int SCREEN_HEIGHT = 512;

  localparam int COORD_W = 32;
  localparam int SV_W    = 24;
  localparam int DIFF_W  = 25;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int EDGE_W  = PROD_W + 2;
  localparam int NUM_W   = 54;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int BOX_W   = 17;
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
  localparam int PIX_W   = 9;
  localparam int COLOR_W = 24;

  localparam int SCALE_X = SCREEN_WIDTH * 128;
  localparam int SCALE_Y = SCREEN_HEIGHT * 128;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_ACCEPT    = 2'd1,
    ST_REJECT    = 2'd2,
    ST_IDLE_STEP = 2'd3
  } status_t;

  typedef struct packed {
    logic       load;
    logic       div_go;
    logic       div_store;
    logic [2:0] div_idx;
    logic       box_latch;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       scan_init;
    logic       scan_adv;
    logic       emit;
    status_t    status;
  } ptr_cmd_t;

  typedef struct packed {
    logic zero_z;
    logic div_done;
    logic area_zero;
    logic box_empty;
    logic fin;
  } ptr_stat_t;

endpackage

[design/ptr_div.sv]
// Iterative floor divider with saturation of the quotient to signed Q16.8.
module ptr_div
  import ptr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [COORD_W-1:0] den,
  output logic                     done,
  output logic signed [SV_W-1:0]   quo_sat
);

  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] dmag_r, dmag_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [COORD_W:0]   rem_sh;
  logic [NUM_W:0]     mag;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    if (go) begin
      quo_nxt  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag_nxt = den[COORD_W-1] ? COORD_W'(-den) : COORD_W'(den);
      neg_nxt  = num[NUM_W-1] ^ den[COORD_W-1];
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dmag_r}) begin
        rem_nxt = COORD_W'(rem_sh - {1'b0, dmag_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[COORD_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  always_comb begin
    mag = {1'b0, quo_r} + ((neg_r && rem_r != '0) ? (NUM_W+1)'(1) : (NUM_W+1)'(0));
    if (!neg_r && mag > (NUM_W+1)'(8388607)) begin
      quo_sat = SV_W'(8388607);
    end else if (neg_r && mag > (NUM_W+1)'(8388608)) begin
      quo_sat = SV_W'(-8388608);
    end else if (neg_r) begin
      quo_sat = SV_W'(-mag);
    end else begin
      quo_sat = SV_W'(mag);
    end
  end

  assign done = done_r;

endmodule

[design/ptr_dp.sv]
// Datapath: vertex capture, projection, bounding box, edge set-up and scan.
module ptr_dp
  import ptr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptr_cmd_t                  cmd,
  output ptr_stat_t                 stat,
  input  logic signed [COORD_W-1:0] vert_x [3],
  input  logic signed [COORD_W-1:0] vert_y [3],
  input  logic signed [COORD_W-1:0] vert_z [3],
  input  logic [COLOR_W-1:0]        fill_color,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [PIX_W-1:0]          out_pixel_col,
  output logic [PIX_W-1:0]          out_pixel_row,
  output logic                      out_covered,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_last
);

  logic signed [COORD_W-1:0] vx_in_r [3];
  logic signed [COORD_W-1:0] vy_in_r [3];
  logic signed [COORD_W-1:0] vz_in_r [3];
  logic [COLOR_W-1:0]        color_r;
  logic signed [SV_W-1:0]    sx_r [3];
  logic signed [SV_W-1:0]    sy_r [3];
  logic [COL_W-1:0]          cmin_r, cmax_r, col_r;
  logic [ROW_W-1:0]          rmin_r, rmax_r, row_r;
  logic                      empty_r;
  logic signed [PROD_W-1:0]  p_r;
  logic                      acc_en_r;
  logic [2:0]                acc_idx_r;
  logic signed [EDGE_W-1:0]  area_r;
  logic signed [EDGE_W-1:0]  e_r [3];
  logic signed [EDGE_W-1:0]  erow_r [3];
  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [PIX_W-1:0]          out_col_r, out_row_r;
  logic                      out_cov_r, out_last_r;
  logic [COLOR_W-1:0]        out_color_r;

  // Projection numerator and divider.
  logic [1:0]                div_k;
  logic signed [COORD_W:0]   sum_s;
  logic signed [NUM_W-1:0]   num;
  logic                      div_done;
  logic signed [SV_W-1:0]    quo_sat;

  assign div_k = cmd.div_idx[2:1];

  always_comb begin
    if (cmd.div_idx[0]) begin
      sum_s = (COORD_W+1)'(vz_in_r[div_k]) + (COORD_W+1)'(vy_in_r[div_k]);
      num   = NUM_W'(sum_s) * NUM_W'(SCALE_Y);
    end else begin
      sum_s = (COORD_W+1)'(vz_in_r[div_k]) + (COORD_W+1)'(vx_in_r[div_k]);
      num   = NUM_W'(sum_s) * NUM_W'(SCALE_X);
    end
  end

  ptr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (cmd.div_go),
    .num     (num),
    .den     (vz_in_r[div_k]),
    .done    (div_done),
    .quo_sat (quo_sat)
  );

  // Bounding box.
  logic signed [BOX_W-1:0] fx [3], cx [3], fy [3], cy [3];
  logic signed [BOX_W-1:0] bcmin, bcmax, brmin, brmax;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fx[k] = BOX_W'(sx_r[k] >>> 8);
      fy[k] = BOX_W'(sy_r[k] >>> 8);
      cx[k] = BOX_W'((DIFF_W'(sx_r[k]) + DIFF_W'(255)) >>> 8);
      cy[k] = BOX_W'((DIFF_W'(sy_r[k]) + DIFF_W'(255)) >>> 8);
    end
    bcmin = fx[0];
    bcmax = cx[0];
    brmin = fy[0];
    brmax = cy[0];
    for (int k = 1; k < 3; k++) begin
      if (fx[k] < bcmin) bcmin = fx[k];
      if (cx[k] > bcmax) bcmax = cx[k];
      if (fy[k] < brmin) brmin = fy[k];
      if (cy[k] > brmax) brmax = cy[k];
    end
    if (bcmin < 0) bcmin = '0;
    if (brmin < 0) brmin = '0;
    if (bcmax > BOX_W'(SCREEN_WIDTH - 1)) bcmax = BOX_W'(SCREEN_WIDTH - 1);
    if (brmax > BOX_W'(SCREEN_HEIGHT - 1)) brmax = BOX_W'(SCREEN_HEIGHT - 1);
  end

  // Edge terms and multiplier operands.
  logic signed [DIFF_W-1:0] px_s, py_s;
  logic signed [DIFF_W-1:0] dy_w [3], dx_w [3], bx_w [3], by_w [3];
  logic signed [EDGE_W-1:0] cstep [3], rstep [3];
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic [1:0]               grp, eidx;

  always_comb begin
    px_s = DIFF_W'(signed'({1'b0, cmin_r, 8'b0}));
    py_s = DIFF_W'(signed'({1'b0, rmin_r, 8'b0}));
    for (int k = 0; k < 3; k++) begin
      dy_w[k]  = DIFF_W'(sy_r[(k+1)%3]) - DIFF_W'(sy_r[(k+2)%3]);
      dx_w[k]  = DIFF_W'(sx_r[(k+2)%3]) - DIFF_W'(sx_r[(k+1)%3]);
      bx_w[k]  = px_s - DIFF_W'(sx_r[(k+1)%3]);
      by_w[k]  = py_s - DIFF_W'(sy_r[(k+1)%3]);
      cstep[k] = EDGE_W'(dy_w[k]) <<< 8;
      rstep[k] = EDGE_W'(dx_w[k]) <<< 8;
    end
    grp  = cmd.mul_idx[2:1];
    eidx = grp - 2'd1;
    if (grp == 2'd0) begin
      if (cmd.mul_idx[0]) begin
        mul_a = DIFF_W'(sx_r[1]) - DIFF_W'(sx_r[0]);
        mul_b = DIFF_W'(sy_r[2]) - DIFF_W'(sy_r[0]);
      end else begin
        mul_a = DIFF_W'(sy_r[0]) - DIFF_W'(sy_r[1]);
        mul_b = DIFF_W'(sx_r[2]) - DIFF_W'(sx_r[0]);
      end
    end else if (cmd.mul_idx[0]) begin
      mul_a = dx_w[eidx];
      mul_b = by_w[eidx];
    end else begin
      mul_a = dy_w[eidx];
      mul_b = bx_w[eidx];
    end
  end

  logic [1:0]               tgt;
  logic [1:0]               tgt_e;
  logic signed [EDGE_W-1:0] p_ext;
  logic                     cov, fin;

  assign tgt   = acc_idx_r[2:1];
  assign tgt_e = tgt - 2'd1;
  assign p_ext = EDGE_W'(p_r);
  assign fin   = (col_r == cmax_r) && (row_r == rmax_r);

  always_comb begin
    if (area_r[EDGE_W-1]) begin
      cov = e_r[0][EDGE_W-1] && e_r[1][EDGE_W-1] && e_r[2][EDGE_W-1];
    end else begin
      cov = (e_r[0] > 0) && (e_r[1] > 0) && (e_r[2] > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_en_r    <= cmd.mul_en;
      out_valid_r <= cmd.emit;
    end

    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        vx_in_r[k] <= vert_x[k];
        vy_in_r[k] <= vert_y[k];
        vz_in_r[k] <= vert_z[k];
      end
      color_r <= fill_color;
    end

    if (cmd.div_store) begin
      if (cmd.div_idx[0]) begin
        sy_r[div_k] <= quo_sat;
      end else begin
        sx_r[div_k] <= quo_sat;
      end
    end

    if (cmd.box_latch) begin
      cmin_r  <= COL_W'(bcmin);
      cmax_r  <= COL_W'(bcmax);
      rmin_r  <= ROW_W'(brmin);
      rmax_r  <= ROW_W'(brmax);
      empty_r <= (bcmin > bcmax) || (brmin > brmax);
    end

    if (cmd.mul_en) begin
      p_r       <= mul_a * mul_b;
      acc_idx_r <= cmd.mul_idx;
    end

    if (acc_en_r) begin
      if (tgt == 2'd0) begin
        area_r <= acc_idx_r[0] ? area_r + p_ext : p_ext;
      end else begin
        e_r[tgt_e]    <= acc_idx_r[0] ? e_r[tgt_e] + p_ext : p_ext;
        erow_r[tgt_e] <= acc_idx_r[0] ? erow_r[tgt_e] + p_ext : p_ext;
      end
    end

    if (cmd.scan_init) begin
      col_r <= cmin_r;
      row_r <= rmin_r;
    end else if (cmd.scan_adv && !fin) begin
      if (col_r == cmax_r) begin
        col_r <= cmin_r;
        row_r <= row_r + ROW_W'(1);
        for (int k = 0; k < 3; k++) begin
          erow_r[k] <= erow_r[k] + rstep[k];
          e_r[k]    <= erow_r[k] + rstep[k];
        end
      end else begin
        col_r <= col_r + COL_W'(1);
        for (int k = 0; k < 3; k++) begin
          e_r[k] <= e_r[k] + cstep[k];
        end
      end
    end

    if (cmd.emit) begin
      out_status_r <= cmd.status;
      case (cmd.status)
        ST_PIXEL: begin
          out_col_r   <= PIX_W'(col_r);
          out_row_r   <= PIX_W'(row_r);
          out_cov_r   <= cov;
          out_color_r <= color_r;
          out_last_r  <= fin;
        end
        ST_ACCEPT: begin
          out_col_r   <= '0;
          out_row_r   <= '0;
          out_cov_r   <= 1'b0;
          out_color_r <= color_r;
          out_last_r  <= 1'b0;
        end
        default: begin
          out_col_r   <= '0;
          out_row_r   <= '0;
          out_cov_r   <= 1'b0;
          out_color_r <= '0;
          out_last_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    stat.zero_z    = (vz_in_r[0] == '0) || (vz_in_r[1] == '0) || (vz_in_r[2] == '0);
    stat.div_done  = div_done;
    stat.area_zero = (area_r == '0);
    stat.box_empty = empty_r;
    stat.fin       = fin;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_col   = out_col_r;
  assign out_pixel_row   = out_row_r;
  assign out_covered     = out_cov_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

endmodule

[design/ptr_ctrl.sv]
// Controller: sequences triangle set-up and drives the pixel scan.
module ptr_ctrl
  import ptr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      op,
  input  ptr_stat_t stat,
  output ptr_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ZCHK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_BOX,
    S_MUL,
    S_MUL_TAIL,
    S_CHK
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.status = ST_PIXEL;
    cmd.div_idx = cnt_r;
    cmd.mul_idx = cnt_r;
    case (state_r)
      S_IDLE, S_SCAN: begin
        if (start) begin
          if (op == OP_START) begin
            cmd.load  = 1'b1;
            state_nxt = S_ZCHK;
          end else if (state_r == S_SCAN) begin
            cmd.scan_adv = 1'b1;
            cmd.emit     = 1'b1;
            cmd.status   = ST_PIXEL;
            if (stat.fin) state_nxt = S_IDLE;
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = ST_IDLE_STEP;
          end
        end
      end
      S_ZCHK: begin
        cnt_nxt = '0;
        if (stat.zero_z) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_REJECT;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (cnt_r == 3'd5) begin
            state_nxt = S_BOX;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_BOX: begin
        cmd.box_latch = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd7) state_nxt = S_MUL_TAIL;
      end
      S_MUL_TAIL: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.emit = 1'b1;
        if (stat.area_zero || stat.box_empty) begin
          cmd.status = ST_REJECT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.status    = ST_ACCEPT;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE) && (state_nxt != S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

[design/perspective_triangle_rasterizer.sv]
// A step beat gives its pixel in the next cycle; step beats are taken every cycle.
// A start beat holds busy through set-up, which is dominated by the shared bit-serial divider.
// A start beat with a zero depth holds busy for one cycle only.
// Accept or reject appears as busy falls; results cannot be stalled by the receiver.
// Synchronous active-low reset leaves no triangle loaded and no result pending.
module perspective_triangle_rasterizer
  import ptr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_op,
  input  logic signed [COORD_W-1:0] in_vert0_x,
  input  logic signed [COORD_W-1:0] in_vert0_y,
  input  logic signed [COORD_W-1:0] in_vert0_z,
  input  logic signed [COORD_W-1:0] in_vert1_x,
  input  logic signed [COORD_W-1:0] in_vert1_y,
  input  logic signed [COORD_W-1:0] in_vert1_z,
  input  logic signed [COORD_W-1:0] in_vert2_x,
  input  logic signed [COORD_W-1:0] in_vert2_y,
  input  logic signed [COORD_W-1:0] in_vert2_z,
  input  logic [COLOR_W-1:0]        in_fill_color,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [PIX_W-1:0]          out_pixel_col,
  output logic [PIX_W-1:0]          out_pixel_row,
  output logic                      out_covered,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_last
);

  ptr_cmd_t                  cmd;
  ptr_stat_t                 stat;
  logic signed [COORD_W-1:0] vx [3], vy [3], vz [3];

  assign vx[0] = in_vert0_x;
  assign vx[1] = in_vert1_x;
  assign vx[2] = in_vert2_x;
  assign vy[0] = in_vert0_y;
  assign vy[1] = in_vert1_y;
  assign vy[2] = in_vert2_y;
  assign vz[0] = in_vert0_z;
  assign vz[1] = in_vert1_z;
  assign vz[2] = in_vert2_z;

  ptr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && !busy),
    .op    (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ptr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .vert_x          (vx),
    .vert_y          (vy),
    .vert_z          (vz),
    .fill_color      (in_fill_color),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pixel_col   (out_pixel_col),
    .out_pixel_row   (out_pixel_row),
    .out_covered     (out_covered),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule

[design/ptr_checker.sv]
// Port-level checks for the rasteriser, bound to the top level.
module ptr_checker
  import ptr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_op,
  input logic               out_valid,
  input logic [1:0]         out_status,
  input logic [PIX_W-1:0]   out_pixel_col,
  input logic               out_covered,
  input logic [COLOR_W-1:0] out_pixel_color,
  input logic               out_last
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == OP_START) |=> busy)
    else $error("start beat did not raise busy");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == OP_STEP) |=> out_valid && !busy)
    else $error("step beat gave no result in the next cycle");

  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && (out_status == ST_ACCEPT || out_status == ST_REJECT))
    else $error("set-up ended without an accept or reject");

  a_non_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PIXEL) |-> !out_covered && !out_last &&
      (out_pixel_col == '0))
    else $error("non-pixel result carries pixel fields");

  a_reject_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJECT || out_status == ST_IDLE_STEP) |->
      (out_pixel_color == '0))
    else $error("rejected result carries a colour");

endmodule

bind perspective_triangle_rasterizer ptr_checker u_chk (.*);

[tb/perspective_triangle_rasterizer_test.sv]
// Self-checking testbench for the perspective triangle rasteriser.
module perspective_triangle_rasterizer_test;
  import ptr_pkg::*;

  typedef struct packed {
    logic               op;
    logic [8:0][31:0]   vert;
    logic [COLOR_W-1:0] color;
  } tri_item_t;

  typedef struct packed {
    status_t            status;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic               covered;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_result_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic signed [COORD_W-1:0] in_vert0_x = '0, in_vert0_y = '0, in_vert0_z = '0;
  logic signed [COORD_W-1:0] in_vert1_x = '0, in_vert1_y = '0, in_vert1_z = '0;
  logic signed [COORD_W-1:0] in_vert2_x = '0, in_vert2_y = '0, in_vert2_z = '0;
  logic [COLOR_W-1:0] in_fill_color = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [PIX_W-1:0] out_pixel_col, out_pixel_row;
  logic out_covered, out_last;
  logic [COLOR_W-1:0] out_pixel_color;

  tri_item_t     pending_items[$];
  pixel_result_t expected_pixels[$];
  tri_item_t     held_item;

  longint scr_x[3], scr_y[3];
  longint col_min, col_max, row_max, scan_c, scan_r;
  bit     area_neg, raster_active;
  logic [COLOR_W-1:0] raster_color;

  int mismatches = 0;
  int n_sent = 0, n_accepted = 0, n_rejected = 0, n_pixels = 0, n_covered = 0;
  int burst_left = 0, gap_left = 0, quiet_cycles = 0;
  bit drain_pending = 1'b0;

  perspective_triangle_rasterizer i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic longint project(longint c, longint z, longint size);
    longint s;
    s = floor_div((z + c) * size * 128, z);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return s;
  endfunction

  function automatic longint edge_fn(int a, int c, longint px, longint py);
    return (scr_y[a] - scr_y[c]) * (px - scr_x[a]) + (scr_x[c] - scr_x[a]) * (py - scr_y[a]);
  endfunction

  function automatic pixel_result_t rasterise(tri_item_t it);
    pixel_result_t r;
    longint x, y, z, area, cmin, cmax, rmin, rmax, ea, eb, ec, px, py;
    longint fx[3], cx[3], fy[3], cy[3];
    bit zero_z, fin, cov;
    r = '0;
    zero_z = 1'b0;
    if (it.op == OP_START) begin
      raster_active = 1'b0;
      for (int k = 0; k < 3; k++) begin
        x = longint'($signed(it.vert[3*k]));
        y = longint'($signed(it.vert[3*k+1]));
        z = longint'($signed(it.vert[3*k+2]));
        if (z == 0) begin
          zero_z = 1'b1;
        end else begin
          scr_x[k] = project(x, z, SCREEN_WIDTH);
          scr_y[k] = project(y, z, SCREEN_HEIGHT);
        end
      end
      r.status = ST_REJECT;
      if (zero_z) return r;
      area = edge_fn(0, 1, scr_x[2], scr_y[2]);
      for (int k = 0; k < 3; k++) begin
        fx[k] = floor_div(scr_x[k], 256);
        cx[k] = -floor_div(-scr_x[k], 256);
        fy[k] = floor_div(scr_y[k], 256);
        cy[k] = -floor_div(-scr_y[k], 256);
      end
      cmin = fx[0]; cmax = cx[0]; rmin = fy[0]; rmax = cy[0];
      for (int k = 1; k < 3; k++) begin
        if (fx[k] < cmin) cmin = fx[k];
        if (cx[k] > cmax) cmax = cx[k];
        if (fy[k] < rmin) rmin = fy[k];
        if (cy[k] > rmax) rmax = cy[k];
      end
      if (cmin < 0) cmin = 0;
      if (rmin < 0) rmin = 0;
      if (cmax > SCREEN_WIDTH - 1) cmax = SCREEN_WIDTH - 1;
      if (rmax > SCREEN_HEIGHT - 1) rmax = SCREEN_HEIGHT - 1;
      if (area == 0 || cmin > cmax || rmin > rmax) return r;
      area_neg = area < 0;
      col_min = cmin; col_max = cmax; row_max = rmax;
      scan_c = cmin; scan_r = rmin;
      raster_color = it.color;
      raster_active = 1'b1;
      r.status = ST_ACCEPT;
      r.color = raster_color;
      return r;
    end
    if (!raster_active) begin
      r.status = ST_IDLE_STEP;
      return r;
    end
    px = scan_c * 256;
    py = scan_r * 256;
    ea = edge_fn(1, 2, px, py);
    eb = edge_fn(2, 0, px, py);
    ec = edge_fn(0, 1, px, py);
    fin = (scan_c == col_max) && (scan_r == row_max);
    cov = area_neg ? (ea < 0 && eb < 0 && ec < 0) : (ea > 0 && eb > 0 && ec > 0);
    r.status = ST_PIXEL;
    r.col = scan_c[PIX_W-1:0];
    r.row = scan_r[PIX_W-1:0];
    r.covered = cov;
    r.color = raster_color;
    r.last = fin;
    if (fin) begin
      raster_active = 1'b0;
    end else if (scan_c == col_max) begin
      scan_c = col_min;
      scan_r++;
    end else begin
      scan_c++;
    end
    return r;
  endfunction

  function automatic tri_item_t step_item();
    tri_item_t it;
    it = '0;
    it.op = OP_STEP;
    for (int k = 0; k < 9; k++) it.vert[k] = $urandom;
    it.color = $urandom;
    return it;
  endfunction

  // Places a vertex at screen position (tx, ty) in pixels for a given depth.
  function automatic tri_item_t place(tri_item_t it, int k, int tx, int ty, int z);
    it.vert[3*k]   = 32'(longint'(z) * (tx - 256) / 256);
    it.vert[3*k+1] = 32'(longint'(z) * (ty - 256) / 256);
    it.vert[3*k+2] = 32'(z);
    return it;
  endfunction

  function automatic tri_item_t small_triangle(int spread);
    tri_item_t it;
    int bx, by, z;
    it = '0;
    it.op = OP_START;
    it.color = $urandom;
    bx = $urandom_range(0, 540) - 14;
    by = $urandom_range(0, 540) - 14;
    for (int k = 0; k < 3; k++) begin
      z = $urandom_range(32'h8000, 32'h40000);
      if ($urandom_range(0, 3) == 0) z = -z;
      it = place(it, k, bx + $urandom_range(0, 2 * spread) - spread,
                 by + $urandom_range(0, 2 * spread) - spread, z);
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_pixels.push_back(rasterise(held_item));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (drain_pending) begin
        start <= 1'b0;
        if (expected_pixels.size() == 0) drain_pending <= 1'b0;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        held_item = pending_items.pop_front();
        in_op <= held_item.op;
        in_vert0_x <= held_item.vert[0]; in_vert0_y <= held_item.vert[1];
        in_vert0_z <= held_item.vert[2]; in_vert1_x <= held_item.vert[3];
        in_vert1_y <= held_item.vert[4]; in_vert1_z <= held_item.vert[5];
        in_vert2_x <= held_item.vert[6]; in_vert2_y <= held_item.vert[7];
        in_vert2_z <= held_item.vert[8];
        in_fill_color <= held_item.color;
        start <= 1'b1;
        n_sent <= n_sent + 1;
        if (n_sent % 400 == 200) drain_pending <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_result_t want, got;
    if (rst_n && out_valid) begin
      got = '{status_t'(out_status), out_pixel_col, out_pixel_row, out_covered,
              out_pixel_color, out_last};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
        case (want.status)
          ST_PIXEL: begin
            n_pixels++;
            if (want.covered) n_covered++;
          end
          ST_ACCEPT: n_accepted++;
          ST_REJECT: n_rejected++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tri_item_t it;
    int steps;
    pending_items.push_back(step_item());
    it = '0;
    it.op = OP_START;
    for (int k = 0; k < 9; k++) it.vert[k] = 32'h7fffffff;
    it.color = 24'hffffff;
    pending_items.push_back(it);
    for (int k = 0; k < 9; k++) it.vert[k] = 32'h80000000;
    pending_items.push_back(it);
    for (int k = 0; k < 3; k++) begin
      it = small_triangle(5);
      it.vert[3*k+2] = '0;
      pending_items.push_back(it);
    end
    it = '0;
    it = place(it, 0, 100, 100, 32'h10000);
    it = place(it, 1, 110, 110, 32'h10000);
    it = place(it, 2, 120, 120, 32'h10000);
    pending_items.push_back(it);
    it = place(it, 0, 700, 700, 32'h10000);
    it = place(it, 1, 710, 705, 32'h10000);
    it = place(it, 2, 705, 720, 32'h10000);
    pending_items.push_back(it);
    it = place(it, 0, -300, -300, 32'h10000);
    it = place(it, 1, 900, -300, 32'h10000);
    it = place(it, 2, 256, 900, -32'h10000);
    pending_items.push_back(it);
    repeat (3) pending_items.push_back(step_item());
    it.color = 24'h5a5a5a;
    it = place(it, 0, 505, 505, 32'h10000);
    it = place(it, 1, 511, 509, 32'h10000);
    it = place(it, 2, 507, 515, 32'h10000);
    pending_items.push_back(it);
    repeat (12) pending_items.push_back(step_item());
    while (pending_items.size() < 1700) begin
      if ($urandom_range(0, 9) == 0) begin
        it = '0;
        it.op = OP_START;
        for (int k = 0; k < 9; k++) it.vert[k] = $urandom;
        it.color = $urandom;
        pending_items.push_back(it);
        repeat ($urandom_range(0, 3)) pending_items.push_back(step_item());
      end else begin
        pending_items.push_back(small_triangle($urandom_range(0, 3) == 0 ? 2 : 6));
        steps = $urandom_range(0, 4) == 0 ? $urandom_range(0, 20) : $urandom_range(20, 180);
        repeat (steps) pending_items.push_back(step_item());
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_pixels.size() != 0);
    repeat (400) @(negedge clk);
    $display("%0d triangles accepted, %0d rejected; %0d pixels scanned, %0d covered",
             n_accepted, n_rejected, n_pixels, n_covered);
    $display("%0d items sent, %0d mismatches", n_sent, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[perspective_triangle_rasterizer.f]
design/ptr_pkg.sv
design/ptr_div.sv
design/ptr_dp.sv
design/ptr_ctrl.sv
design/perspective_triangle_rasterizer.sv
design/ptr_checker.sv
tb/perspective_triangle_rasterizer_test.sv
